// ===== rtl/core/mit_pkg.sv =====
// ----------------------------------------------------------------------------
// mit_pkg
// Shared sizes, codes, activation tables and helpers for the two-layer
// perceptron with output-layer training.
// ----------------------------------------------------------------------------
package mit_pkg;

    localparam int INPUTS  = 10;
    localparam int HIDDEN  = 20;
    localparam int OUTPUTS = 5;

    localparam int HB_BASE = HIDDEN * INPUTS;
    localparam int OW_BASE = HB_BASE + HIDDEN;
    localparam int OB_BASE = OW_BASE + OUTPUTS * HIDDEN;
    localparam int NW      = OB_BASE + OUTPUTS;
    localparam int RAW     = $clog2(NW);

    localparam int IW   = (INPUTS > 1) ? $clog2(INPUTS) : 1;
    localparam int HW   = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
    localparam int OXW  = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
    localparam int NMAX = (HIDDEN > OUTPUTS) ? HIDDEN : OUTPUTS;
    localparam int NCW  = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int TMAX = (INPUTS > HIDDEN) ? INPUTS : HIDDEN;
    localparam int TCW  = $clog2(TMAX + 2);

    localparam logic [2:0] OP_WEIGHT  = 3'd0;
    localparam logic [2:0] OP_FEATURE = 3'd1;
    localparam logic [2:0] OP_TARGET  = 3'd2;
    localparam logic [2:0] OP_RUN     = 3'd3;
    localparam logic [2:0] OP_TRAIN   = 3'd4;

    localparam logic KIND_SCORE = 1'b0;
    localparam logic KIND_TRAIN = 1'b1;

    localparam logic [15:0]        LR_RESET = 16'd655;
    localparam logic signed [15:0] ONE_Q12  = 16'sd4096;

    typedef struct packed {
        logic        kind;
        logic [4:0]  index;
        logic [12:0] score;
        logic        complete;
        logic        last;
    } res_t;

    localparam logic signed [13:0] SIG_TAB [0:64] = '{
        1, 2, 2, 3, 4, 5, 6, 8, 10, 13, 17, 21, 27, 35, 45, 58,
        74, 94, 120, 153, 194, 246, 311, 391, 488, 606, 747, 912, 1102, 1314, 1546, 1793,
        2048,
        2303, 2550, 2782, 2994, 3184, 3349, 3490, 3608, 3705, 3785, 3850, 3902, 3943, 3976,
        4002, 4022, 4038, 4051, 4061, 4069, 4075, 4079, 4083, 4086, 4088, 4090, 4091, 4092,
        4093, 4094, 4094, 4095
    };

    localparam logic signed [13:0] TANH_TAB [0:64] = '{
        -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096, -4096,
        -4096, -4095, -4095, -4094, -4093, -4091, -4089, -4084, -4076, -4062, -4041, -4006,
        -3949, -3856, -3707, -3475, -3119, -2602, -1893, -1003,
        0,
        1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949, 4006, 4041, 4062, 4076, 4084, 4089,
        4091, 4093, 4094, 4095, 4095,
        4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096
    };

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // interpolated table read, 64 segments over -8..8
    function automatic logic signed [15:0] act_lookup(input logic use_sig,
                                                      input logic signed [15:0] x);
        logic [15:0]        u;
        logic [5:0]         idx;
        logic [6:0]         idx1;
        logic signed [13:0] t0;
        logic signed [13:0] t1;
        logic signed [14:0] diff;
        logic signed [25:0] prod;
        u    = x ^ 16'h8000;
        idx  = u[15:10];
        idx1 = {1'b0, idx} + 7'd1;
        t0   = use_sig ? SIG_TAB[idx] : TANH_TAB[idx];
        t1   = use_sig ? SIG_TAB[idx1] : TANH_TAB[idx1];
        diff = 15'(t1) - 15'(t0);
        prod = 26'(diff) * 26'($signed({1'b0, u[9:0]}));
        return 16'(t0) + 16'(prod >>> 10);
    endfunction

endpackage

// ===== rtl/core/mit_wram.sv =====
// ----------------------------------------------------------------------------
// mit_wram
// Single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mit_wram #(
    parameter int DEPTH = 325,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/mit_engine.sv =====
// ----------------------------------------------------------------------------
// mit_engine
// Command sequencer with a shared multiplier: forward pass through the
// weight RAM, activation lookup, delta-rule update of the output layer.
// ----------------------------------------------------------------------------
module mit_engine import mit_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            in_op,
    input  logic [9:0]            in_addr,
    input  logic [4:0]            in_idx,
    input  logic signed [15:0]    in_value,
    input  logic                  lr_we,
    input  logic [15:0]           lr_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res,
    output logic                  ram_we,
    output logic [RAW-1:0]        ram_waddr,
    output logic signed [15:0]    ram_wdata,
    output logic [RAW-1:0]        ram_raddr,
    input  logic signed [15:0]    ram_rdata
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_ACT  = 4'd2;
    localparam logic [3:0] T_Y    = 4'd3;
    localparam logic [3:0] T_E    = 4'd4;
    localparam logic [3:0] T_D    = 4'd5;
    localparam logic [3:0] T_LR   = 4'd6;
    localparam logic [3:0] T_LD   = 4'd7;
    localparam logic [3:0] W_RD   = 4'd8;
    localparam logic [3:0] W_LO   = 4'd9;
    localparam logic [3:0] W_HI   = 4'd10;
    localparam logic [3:0] W_WR   = 4'd11;
    localparam logic [3:0] B_RD   = 4'd12;
    localparam logic [3:0] B_WR   = 4'd13;
    localparam logic [3:0] S_EMIT = 4'd14;

    logic [3:0]          state_reg, state_next;
    logic                layer_reg;
    logic [NCW-1:0]      n_reg;
    logic [TCW-1:0]      t_reg;
    logic                train_reg;
    logic                ok_reg;
    logic [15:0]         lr_reg;
    logic [INPUTS-1:0]   feat_pres_reg;
    logic [OUTPUTS-1:0]  tgt_pres_reg;
    logic                s1_v_reg, s1_last_reg, s2_v_reg, s2_last_reg;
    logic signed [15:0]  s1_act_reg;
    logic signed [39:0]  acc_reg;
    logic signed [52:0]  prod_reg;
    logic signed [16:0]  e_reg;
    logic signed [26:0]  d_reg;
    logic signed [43:0]  ld_reg;
    logic signed [15:0]  w_reg;
    logic signed [36:0]  lo_reg;

    logic signed [15:0]  feat_mem [0:INPUTS-1];
    logic signed [15:0]  tgt_mem  [0:OUTPUTS-1];
    logic signed [15:0]  hid_mem  [0:HIDDEN-1];
    logic [12:0]         oact_mem [0:OUTPUTS-1];

    logic                accept, fok, tok, issue, n_last, s_last;
    logic [TCW-1:0]      tm1, n_terms;
    logic [HW-1:0]       hid_idx;
    logic signed [15:0]  feat_q, hid_q, act_sel, x_q, x_act;
    logic [12:0]         y_q;
    logic signed [15:0]  tgt_q;
    int                  addr_int;
    logic signed [27:0]  mul_a;
    logic signed [24:0]  mul_b;
    logic signed [39:0]  ph_s;
    logic signed [60:0]  sum_w;
    logic signed [15:0]  w_new, b_new;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign fok      = &feat_pres_reg;
    assign tok      = &tgt_pres_reg;
    assign tm1      = t_reg - 1'b1;
    assign n_terms  = layer_reg ? TCW'(HIDDEN) : TCW'(INPUTS);
    assign issue    = (state_reg == S_MAC) && (t_reg <= n_terms);
    assign hid_idx  = (state_reg == S_MAC) ? tm1[HW-1:0] : t_reg[HW-1:0];
    assign feat_q   = feat_mem[tm1[IW-1:0]];
    assign hid_q    = hid_mem[hid_idx];
    assign y_q      = oact_mem[n_reg[OXW-1:0]];
    assign tgt_q    = tgt_mem[n_reg[OXW-1:0]];
    assign act_sel  = (t_reg == '0) ? ONE_Q12 : (layer_reg ? hid_q : feat_q);
    assign s_last   = (n_reg == NCW'(OUTPUTS - 1));
    assign n_last   = layer_reg ? s_last : (n_reg == NCW'(HIDDEN - 1));
    assign x_q      = sat16(32'(acc_reg >>> 12));
    assign x_act    = act_lookup(layer_reg, x_q);

    always_comb begin
        addr_int = 0;
        case (state_reg)
            S_MAC: begin
                if (t_reg == '0) begin
                    addr_int = layer_reg ? OB_BASE + int'(n_reg) : HB_BASE + int'(n_reg);
                end else if (layer_reg) begin
                    addr_int = OW_BASE + int'(n_reg) * HIDDEN + int'(tm1);
                end else begin
                    addr_int = int'(n_reg) * INPUTS + int'(tm1);
                end
            end
            W_RD, W_LO, W_HI, W_WR: begin
                addr_int = OW_BASE + int'(n_reg) * HIDDEN + int'(t_reg);
            end
            B_RD, B_WR: begin
                addr_int = OB_BASE + int'(n_reg);
            end
            default: begin
                addr_int = 0;
            end
        endcase
    end

    // weight update: ld*h split into a low and a high partial product
    assign ph_s  = prod_reg[39:0];
    assign sum_w = (61'(ph_s) <<< 20) + 61'(lo_reg);
    assign w_new = sat16(32'(w_reg) + 32'($signed(sum_w[60:40])));
    assign b_new = sat16(32'(ram_rdata) + 32'($signed(ld_reg[43:28])));

    assign ram_raddr = RAW'(addr_int);
    assign ram_we    = (accept && in_op == OP_WEIGHT && in_addr < 10'(NW))
                       || state_reg == W_WR || state_reg == B_WR;
    assign ram_waddr = (state_reg == S_IDLE) ? in_addr[RAW-1:0] : RAW'(addr_int);
    assign ram_wdata = (state_reg == S_IDLE) ? in_value :
                       ((state_reg == W_WR) ? w_new : b_new);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MAC: begin
                mul_a = 28'(ram_rdata);
                mul_b = 25'(s1_act_reg);
            end
            T_Y: begin
                mul_a = 28'($signed({1'b0, y_q}));
                mul_b = 25'sd4096 - 25'($signed({1'b0, y_q}));
            end
            T_E: begin
                mul_a = 28'(e_reg);
                mul_b = $signed(prod_reg[24:0]);
            end
            T_LR: begin
                mul_a = 28'(d_reg);
                mul_b = 25'($signed({1'b0, lr_reg}));
            end
            W_LO: begin
                mul_a = 28'($signed({1'b0, ld_reg[19:0]}));
                mul_b = 25'(hid_q);
            end
            W_HI: begin
                mul_a = 28'($signed(ld_reg[43:20]));
                mul_b = 25'(hid_q);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign res_valid    = (state_reg == S_EMIT);
    assign res.kind     = train_reg ? KIND_TRAIN : KIND_SCORE;
    assign res.index    = train_reg ? 5'd0 : 5'(n_reg);
    assign res.score    = (!train_reg && ok_reg) ? y_q : 13'd0;
    assign res.complete = ok_reg;
    assign res.last     = train_reg || s_last;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && in_op == OP_RUN) begin
                    state_next = fok ? S_MAC : S_EMIT;
                end else if (accept && in_op == OP_TRAIN) begin
                    state_next = (fok && tok) ? S_MAC : S_EMIT;
                end
            end
            S_MAC: begin
                if (s2_v_reg && s2_last_reg) begin
                    state_next = S_ACT;
                end
            end
            S_ACT: begin
                if (n_last && layer_reg) begin
                    state_next = train_reg ? T_Y : S_EMIT;
                end else begin
                    state_next = S_MAC;
                end
            end
            T_Y:  state_next = T_E;
            T_E:  state_next = T_D;
            T_D:  state_next = T_LR;
            T_LR: state_next = T_LD;
            T_LD: state_next = W_RD;
            W_RD: state_next = W_LO;
            W_LO: state_next = W_HI;
            W_HI: state_next = W_WR;
            W_WR: state_next = (t_reg == TCW'(HIDDEN - 1)) ? B_RD : W_RD;
            B_RD: state_next = B_WR;
            B_WR: state_next = s_last ? S_EMIT : T_Y;
            S_EMIT: begin
                if (res_ready && res.last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            lr_reg        <= LR_RESET;
            feat_pres_reg <= '0;
            tgt_pres_reg  <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            layer_reg     <= 1'b0;
            n_reg         <= '0;
            t_reg         <= '0;
            train_reg     <= 1'b0;
            ok_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            s1_v_reg  <= issue;
            s2_v_reg  <= s1_v_reg;
            if (lr_we) begin
                lr_reg <= lr_data;
            end
            if (accept && in_op == OP_FEATURE && in_idx < 5'(INPUTS)) begin
                feat_pres_reg[in_idx[IW-1:0]] <= 1'b1;
            end
            if (accept && in_op == OP_TARGET && in_idx < 5'(OUTPUTS)) begin
                tgt_pres_reg[in_idx[OXW-1:0]] <= 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    layer_reg <= 1'b0;
                    n_reg     <= '0;
                    t_reg     <= '0;
                    if (accept && in_op == OP_RUN) begin
                        train_reg <= 1'b0;
                        ok_reg    <= fok;
                    end else if (accept && in_op == OP_TRAIN) begin
                        train_reg <= 1'b1;
                        ok_reg    <= fok && tok;
                    end
                end
                S_MAC: begin
                    if (issue) begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                S_ACT: begin
                    t_reg <= '0;
                    if (n_last) begin
                        n_reg     <= '0;
                        layer_reg <= 1'b1;
                    end else begin
                        n_reg <= n_reg + 1'b1;
                    end
                end
                T_LD: t_reg <= '0;
                W_WR: t_reg <= t_reg + 1'b1;
                B_WR: begin
                    n_reg <= s_last ? '0 : n_reg + 1'b1;
                end
                S_EMIT: begin
                    if (res_ready) begin
                        n_reg <= n_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge clk) begin
        prod_reg    <= mul_a * mul_b;
        s1_last_reg <= issue && (t_reg == n_terms);
        s1_act_reg  <= act_sel;
        s2_last_reg <= s1_last_reg;
        if (accept && in_op == OP_FEATURE && in_idx < 5'(INPUTS)) begin
            feat_mem[in_idx[IW-1:0]] <= in_value;
        end
        if (accept && in_op == OP_TARGET && in_idx < 5'(OUTPUTS)) begin
            tgt_mem[in_idx[OXW-1:0]] <= in_value;
        end
        if (state_reg != S_MAC) begin
            acc_reg <= '0;
        end else if (s2_v_reg) begin
            acc_reg <= acc_reg + prod_reg[39:0];
        end
        if (state_reg == S_ACT) begin
            if (layer_reg) begin
                oact_mem[n_reg[OXW-1:0]] <= x_act[12:0];
            end else begin
                hid_mem[n_reg[HW-1:0]] <= x_act;
            end
        end
        if (state_reg == T_Y) begin
            e_reg <= 17'(tgt_q) - 17'($signed({1'b0, y_q}));
        end
        if (state_reg == T_D) begin
            d_reg <= prod_reg[38:12];
        end
        if (state_reg == T_LD) begin
            ld_reg <= prod_reg[43:0];
        end
        if (state_reg == W_LO) begin
            w_reg <= ram_rdata;
        end
        if (state_reg == W_HI) begin
            lo_reg <= prod_reg[36:0];
        end
    end

endmodule

// ===== rtl/core/mlp_infer_and_output_train.sv =====
// ----------------------------------------------------------------------------
// mlp_infer_and_output_train
// Two-layer perceptron, Q4.12, with delta-rule training of the output layer.
//
//   channel   dir  handshake          payload
//   s_        in   tvalid/tready      tuser op, tdata address/index/value
//   cfg_      in   wr_en              wr_data learning rate, Q0.16
//   m_        out  tvalid/tready      tuser kind, tlast, tdata index/score/complete
//
// weight, feature and target words are stored without leaving idle
// run: the forward pass is paced by the single weight RAM read port
//   feeding one shared multiplier, then one score word per cycle while
//   the output register can take it
// train then runs T_Y to T_LD per output, W_RD/W_LO/W_HI/W_WR per weight
// reset clears control and presence flags; stores hold garbage until written
// a full output register stalls the sequencer only while words are emitted
// ----------------------------------------------------------------------------
module mlp_infer_and_output_train import mit_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // param_address, element_index, value, pad
    input  logic [2:0]  s_tuser,     // op
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // output_index, score, complete, pad
    output logic        m_tuser,     // kind
    output logic        m_tlast
);

    logic               res_valid, res_ready;
    res_t               res;
    logic               m_valid_reg;
    res_t               m_res_reg;
    logic               ram_we;
    logic [RAW-1:0]     ram_waddr, ram_raddr;
    logic signed [15:0] ram_wdata, ram_rdata;

    assign res_ready = !m_valid_reg || m_tready;

    mit_engine u_engine (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_addr   (s_tdata[9:0]),
        .in_idx    (s_tdata[14:10]),
        .in_value  ($signed(s_tdata[30:15])),
        .lr_we     (cfg_wr_en),
        .lr_data   (cfg_wr_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    mit_wram #(
        .DEPTH (NW),
        .WIDTH (16)
    ) u_wram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_res_reg.complete, m_res_reg.score, m_res_reg.index};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;

endmodule

// ===== rtl/core/mit_checker.sv =====
// ----------------------------------------------------------------------------
// mit_checker
// Port-level checks on the perceptron's output words and command handling.
// ----------------------------------------------------------------------------
module mit_checker import mit_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        cfg_wr_en,
    input logic [15:0] cfg_wr_data,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_RUN || s_tuser == OP_TRAIN) |=> !s_tready)
        else $error("command did not occupy the block");

    a_train_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_TRAIN |-> m_tlast && m_tdata[17:0] == 18'd0)
        else $error("bad training word");

    a_incomplete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[18] |-> m_tdata[17:5] == 13'd0)
        else $error("score on incomplete word");

    a_last_score: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SCORE && m_tlast |-> m_tdata[4:0] == 5'(OUTPUTS - 1))
        else $error("last score word has wrong index");

endmodule

bind mlp_infer_and_output_train mit_checker u_mit_checker (.*);

// ===== tb/sv/mlp_score_checker.sv =====
// ----------------------------------------------------------------------------
// mlp_score_checker
// Watches the command, configuration and result channels of the perceptron,
// keeps its own copy of weights, features, targets and learning rate, works
// out the score and training words each command should give and compares
// every result word with the oldest one still expected.
// ----------------------------------------------------------------------------
module mlp_score_checker import mit_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,     // param_address, element_index, value, pad
    input  logic [2:0]  s_tuser,     // op
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,     // output_index, score, complete, pad
    input  logic        m_tuser,     // kind
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    int               weights [NW];
    int               features [INPUTS];
    int               targets [OUTPUTS];
    int               hidden_act [HIDDEN];
    int               score_act [OUTPUTS];
    logic [INPUTS-1:0]  feat_seen;
    logic [OUTPUTS-1:0] targ_seen;
    logic [15:0]      rate;
    res_t             expected_words [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    function automatic int clip16(longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return int'(v);
    endfunction

    function automatic int interp(bit sig, int x);
        int u, seg, frac, t0, t1;
        u    = (x + 32768) & 16'hffff;
        seg  = u >> 10;
        frac = u & 1023;
        t0   = sig ? int'(SIG_TAB[seg]) : int'(TANH_TAB[seg]);
        t1   = sig ? int'(SIG_TAB[seg + 1]) : int'(TANH_TAB[seg + 1]);
        return t0 + (((t1 - t0) * frac) >>> 10);
    endfunction

    function automatic void evaluate_network();
        longint acc;
        for (int h = 0; h < HIDDEN; h++) begin
            acc = longint'(weights[HB_BASE + h]) * 4096;
            for (int i = 0; i < INPUTS; i++) begin
                acc += longint'(weights[h * INPUTS + i]) * features[i];
            end
            hidden_act[h] = interp(1'b0, clip16(acc >>> 12));
        end
        for (int o = 0; o < OUTPUTS; o++) begin
            acc = longint'(weights[OB_BASE + o]) * 4096;
            for (int h = 0; h < HIDDEN; h++) begin
                acc += longint'(weights[OW_BASE + o * HIDDEN + h]) * hidden_act[h];
            end
            score_act[o] = interp(1'b1, clip16(acc >>> 12));
        end
    endfunction

    function automatic void adjust_output_layer();
        longint y, err, delta, step;
        int     a;
        for (int o = 0; o < OUTPUTS; o++) begin
            y     = score_act[o];
            err   = longint'(targets[o]) - y;
            delta = (err * y * (4096 - y)) >>> 12;
            step  = longint'(rate) * delta;
            for (int h = 0; h < HIDDEN; h++) begin
                a = OW_BASE + o * HIDDEN + h;
                weights[a] = clip16(longint'(weights[a]) + ((step * hidden_act[h]) >>> 40));
            end
            weights[OB_BASE + o] = clip16(longint'(weights[OB_BASE + o]) + (step >>> 28));
        end
    endfunction

    function automatic void predict_word(logic [2:0] op, logic [31:0] d);
        logic [9:0] addr;
        logic [4:0] idx;
        int         val;
        bit         fok, tok;
        res_t       r;
        addr = d[9:0];
        idx  = d[14:10];
        val  = int'($signed(d[30:15]));
        fok  = &feat_seen;
        tok  = &targ_seen;
        case (op)
            OP_WEIGHT: begin
                if (addr < NW) begin
                    weights[addr] = val;
                end
            end
            OP_FEATURE: begin
                if (idx < INPUTS) begin
                    features[idx]  = val;
                    feat_seen[idx] = 1'b1;
                end
            end
            OP_TARGET: begin
                if (idx < OUTPUTS) begin
                    targets[idx]   = val;
                    targ_seen[idx] = 1'b1;
                end
            end
            OP_RUN: begin
                if (fok) begin
                    evaluate_network();
                end
                for (int o = 0; o < OUTPUTS; o++) begin
                    r.kind     = KIND_SCORE;
                    r.index    = 5'(o);
                    r.score    = fok ? 13'(score_act[o]) : 13'd0;
                    r.complete = fok;
                    r.last     = (o == OUTPUTS - 1);
                    expected_words = {expected_words, r};
                end
            end
            OP_TRAIN: begin
                if (fok && tok) begin
                    evaluate_network();
                    adjust_output_layer();
                end
                r.kind     = KIND_TRAIN;
                r.index    = '0;
                r.score    = '0;
                r.complete = fok && tok;
                r.last     = 1'b1;
                expected_words = {expected_words, r};
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        res_t got, want;
        if (!aresetn) begin
            feat_seen = '0;
            targ_seen = '0;
            rate      = LR_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[4:0], m_tdata[17:5], m_tdata[18], m_tlast};
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result word %p", got);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("result mismatch: expected %p, got %p", want, got);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                rate = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                predict_word(s_tuser, s_tdata);
            end
        end
        pending = expected_words.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives weight, feature, target, run, train and unused-op commands into the
// perceptron with random gaps and result back-pressure, steps the learning
// rate through several values between phases, reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import mit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    int          errors;
    int          pending;
    int          n_words = 0;
    int          n_cmds = 0;
    bit          calm = 1'b0;

    always #6 aclk = ~aclk;

    mlp_infer_and_output_train i_dut (.*);

    mlp_score_checker i_checker (.*);

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (calm || p < 65) begin
            return 0;
        end
        if (p < 95) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(60, 15);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        int hold;
        if (hold > 0) begin
            hold--;
            m_tready <= 1'b0;
        end else begin
            hold = gap_len();
            m_tready <= (hold == 0);
        end
    end

    task automatic send(logic [2:0] op, logic [9:0] addr, logic [4:0] idx,
                        logic [15:0] val);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, val, idx, addr};
        do @(posedge aclk); while (!s_tready);
        n_words++;
        if (op == OP_RUN || op == OP_TRAIN) begin
            n_cmds++;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_rate(logic [15:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [15:0] some_value(bit wide);
        if (wide || $urandom_range(9) == 0) begin
            return 16'($urandom);
        end
        return 16'($signed(12'($urandom)));
    endfunction

    task automatic random_phase(int count);
        int p;
        repeat (count) begin
            p = $urandom_range(99);
            if (p < 35) begin
                send(OP_WEIGHT, 10'($urandom_range(p < 3 ? 1023 : NW - 1)), 5'($urandom),
                     some_value(1'b0));
            end else if (p < 62) begin
                send(OP_FEATURE, 10'($urandom),
                     5'($urandom_range(p < 60 ? INPUTS - 1 : 31)), some_value(1'b0));
            end else if (p < 78) begin
                send(OP_TARGET, 10'($urandom),
                     5'($urandom_range(p < 76 ? OUTPUTS - 1 : 31)),
                     16'($urandom_range(p < 74 ? 4096 : 65535)));
            end else if (p < 88) begin
                send(OP_RUN, 10'($urandom), 5'($urandom), 16'($urandom));
            end else if (p < 97) begin
                send(OP_TRAIN, 10'($urandom), 5'($urandom), 16'($urandom));
            end else begin
                send(3'($urandom_range(7, 5)), 10'($urandom), 5'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // commands before anything is present
        send(OP_RUN, '0, '0, '0);
        send(OP_TRAIN, '0, '0, '0);
        calm = 1'b1;
        for (int a = 0; a < NW; a++) begin
            send(OP_WEIGHT, 10'(a), '0, some_value(1'b0));
        end
        calm = 1'b0;

        send(OP_WEIGHT, 10'd1023, 5'd31, 16'h7fff);
        send(OP_WEIGHT, 10'(NW), '0, 16'h8000);
        send(OP_WEIGHT, 10'(OB_BASE), '0, 16'h7fff);
        send(OP_WEIGHT, 10'(HB_BASE), '0, 16'h8000);
        send(OP_FEATURE, '0, 5'd31, 16'h1000);
        send(OP_FEATURE, '0, 5'(INPUTS), 16'h1000);
        for (int i = 0; i < INPUTS; i++) begin
            send(OP_FEATURE, 10'h3ff, 5'(i), i == 0 ? 16'h8000 : (i == 1 ? 16'h7fff :
                 some_value(1'b0)));
        end
        send(OP_RUN, 10'h3ff, 5'd31, 16'hffff);
        send(OP_TRAIN, '0, '0, '0);
        send(OP_TARGET, '0, 5'd31, 16'h1000);
        for (int o = 0; o < OUTPUTS; o++) begin
            send(OP_TARGET, '0, 5'(o), o == 0 ? 16'h8000 : (o == 1 ? 16'h7fff : 16'h0800));
        end
        send(OP_TRAIN, '0, '0, '0);
        for (int op = 5; op < 8; op++) begin
            send(3'(op), 10'h3ff, 5'd31, 16'hffff);
        end
        send(OP_RUN, '0, '0, '0);

        set_rate(16'hffff);
        send(OP_TRAIN, '0, '0, '0);
        send(OP_RUN, '0, '0, '0);
        set_rate(16'd0);
        random_phase(12);
        set_rate(16'($urandom));
        calm = 1'b1;
        random_phase(8);
        calm = 1'b0;
        set_rate(16'd1);
        random_phase(8);
        set_rate(LR_RESET);
        random_phase(12);
        drain();

        $display("sent %0d words including %0d run/train commands,", n_words, n_cmds);
        $display("learning rate stepped through zero, one, full scale and random values");
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d results outstanding", pending);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
